/* rtl/core/assert_macros.svh */
// Assertion macros used by the top level of the click/hold classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true on a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/core/bchc_pkg.sv */
// Types and constants of the button click/hold classifier.
`timescale 1ns / 1ps

package bchc_pkg;

  localparam int TickW = 16;
  localparam int ColourW = 2;
  localparam int CfgIdxW = 2;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLICK    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD     = 2'd2;

  // Register reset values.
  localparam logic [TickW-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [TickW-1:0] CLICK_RST    = 16'd250;
  localparam logic [TickW-1:0] HOLD_RST     = 16'd2700;

  localparam logic [TickW-1:0] TICK_MAX = 16'hFFFF;

  // Colour codes.
  localparam logic [ColourW-1:0] COL_OFF   = 2'd0;
  localparam logic [ColourW-1:0] COL_RED   = 2'd1;
  localparam logic [ColourW-1:0] COL_GREEN = 2'd2;
  localparam logic [ColourW-1:0] COL_BLUE  = 2'd3;

  // Press phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_DEBOUNCE = 4'b0010,
    PH_CLICK    = 4'b0100,
    PH_HOLD     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [TickW-1:0] debounce_ticks;
    logic [TickW-1:0] click_ticks;
    logic [TickW-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic [TickW-1:0] elapsed;
    logic             edge_latched;
    logic             last_level;
    logic [ColourW-1:0] colour;
  } state_t;

  typedef struct packed {
    logic               red_on;
    logic               green_on;
    logic               blue_on;
    logic [ColourW-1:0] colour_index;
    logic               click_seen;
    logic               hold_seen;
  } res_t;

endpackage

/* rtl/core/bchc_step.sv */
// One-tick update of the press classifier: next state and result for one level sample.
`timescale 1ns / 1ps

module bchc_step (
  input  bchc_pkg::cfg_t   cfg,
  input  bchc_pkg::state_t st,
  input  logic             level,
  output bchc_pkg::state_t st_next,
  output bchc_pkg::res_t   res
);

  logic                        pressed;
  logic                        edge_now;
  logic [bchc_pkg::TickW-1:0]  limit;
  logic                        expired;
  logic [bchc_pkg::TickW-1:0]  elapsed_inc;
  logic                        click;
  logic                        hold;
  logic [bchc_pkg::ColourW-1:0] colour_step;

  assign pressed  = ~level;
  // falling edge this tick is visible to the idle check right away
  assign edge_now = st.edge_latched | (st.last_level & ~level);

  // one shared compare against the current wait's length
  always_comb begin
    unique case (st.phase)
      bchc_pkg::PH_DEBOUNCE: limit = cfg.debounce_ticks;
      bchc_pkg::PH_CLICK:    limit = cfg.click_ticks;
      bchc_pkg::PH_HOLD:     limit = cfg.hold_ticks;
      default:               limit = cfg.debounce_ticks;
    endcase
  end

  assign expired     = st.elapsed >= limit;
  assign elapsed_inc = (st.elapsed == bchc_pkg::TICK_MAX) ? st.elapsed
                                                          : st.elapsed + 16'd1;
  assign colour_step = (st.colour == bchc_pkg::COL_BLUE) ? bchc_pkg::COL_RED
                                                         : st.colour + 2'd1;

  // phase transitions
  always_comb begin
    st_next              = st;
    st_next.edge_latched = edge_now;
    st_next.last_level   = level;
    click                = 1'b0;
    hold                 = 1'b0;
    unique case (st.phase)
      bchc_pkg::PH_IDLE: begin
        if (edge_now && pressed) begin
          st_next.phase   = bchc_pkg::PH_DEBOUNCE;
          st_next.elapsed = '0;
        end
      end
      bchc_pkg::PH_DEBOUNCE: begin
        if (pressed && expired) begin
          st_next.phase   = bchc_pkg::PH_CLICK;
          st_next.elapsed = '0;
        end else if (pressed) begin
          st_next.elapsed = elapsed_inc;
        end else begin
          st_next.phase        = bchc_pkg::PH_IDLE;
          st_next.elapsed      = '0;
          st_next.edge_latched = 1'b0;
        end
      end
      bchc_pkg::PH_CLICK: begin
        if (pressed && expired) begin
          st_next.phase   = bchc_pkg::PH_HOLD;
          st_next.elapsed = '0;
        end else if (pressed) begin
          st_next.elapsed = elapsed_inc;
        end else begin
          // release inside the window is a click; late release does nothing
          if (!expired) begin
            st_next.colour = colour_step;
            click          = 1'b1;
          end
          st_next.phase        = bchc_pkg::PH_IDLE;
          st_next.elapsed      = '0;
          st_next.edge_latched = 1'b0;
        end
      end
      bchc_pkg::PH_HOLD: begin
        if (pressed && !expired) begin
          st_next.elapsed = elapsed_inc;
        end else begin
          if (pressed) begin
            st_next.colour = bchc_pkg::COL_OFF;
            hold           = 1'b1;
          end
          st_next.phase        = bchc_pkg::PH_IDLE;
          st_next.elapsed      = '0;
          st_next.edge_latched = 1'b0;
        end
      end
      default: begin
        st_next.phase        = bchc_pkg::PH_IDLE;
        st_next.elapsed      = '0;
        st_next.edge_latched = 1'b0;
      end
    endcase
  end

  // result from the updated colour
  assign res.red_on       = st_next.colour == bchc_pkg::COL_RED;
  assign res.green_on     = st_next.colour == bchc_pkg::COL_GREEN;
  assign res.blue_on      = st_next.colour == bchc_pkg::COL_BLUE;
  assign res.colour_index = st_next.colour;
  assign res.click_seen   = click;
  assign res.hold_seen    = hold;

endmodule

/* rtl/core/button_click_hold_classifier.sv */
// Top level of the button click/hold classifier: input stage, state, result queue.
//
//   channel  direction  signals                      moves
//   in       sink       in_valid/in_ready            one level sample (tick)
//   out      source     out_valid/out_ready          one result per tick
//   cfg      sink       cfg_write/cfg_index/cfg_data register write, no wait
//
// One tick per cycle sustained while the receiver keeps taking results; a tick
// passes the input register, then the step logic into a two-entry result queue.
// The queue lets a new tick in while an earlier result waits to be taken;
// in_ready drops only when the input register holds a tick and the queue is
// full with no pop. Reset (rst, synchronous) restores idle, colour off and the
// register defaults; it leaves no pending transactions.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module button_click_hold_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          button_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          red_on,
  output logic                          green_on,
  output logic                          blue_on,
  output logic [bchc_pkg::ColourW-1:0]  colour_index,
  output logic                          click_seen,
  output logic                          hold_seen,
  input  logic                          cfg_write,
  input  logic [bchc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bchc_pkg::TickW-1:0]    cfg_data
);

  bchc_pkg::cfg_t   cfg;
  bchc_pkg::state_t st;
  bchc_pkg::state_t st_next;
  bchc_pkg::res_t   step_res;
  bchc_pkg::res_t   q_mem [2];
  bchc_pkg::res_t   q_head;

  logic       s1_valid;
  logic       s1_level;
  logic       s1_fire;
  logic       q_room;
  logic       q_pop;
  logic       q_wr;
  logic       q_rd;
  logic [1:0] q_count;
  logic [1:0] q_count_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= bchc_pkg::DEBOUNCE_RST;
      cfg.click_ticks    <= bchc_pkg::CLICK_RST;
      cfg.hold_ticks     <= bchc_pkg::HOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bchc_pkg::CFG_DEBOUNCE: cfg.debounce_ticks <= cfg_data;
        bchc_pkg::CFG_CLICK:    cfg.click_ticks    <= cfg_data;
        bchc_pkg::CFG_HOLD:     cfg.hold_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  assign q_room   = (q_count != 2'd2) || out_ready;
  assign s1_fire  = s1_valid && q_room;
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_level <= button_level;
    end
  end

  // step logic
  bchc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .level   (s1_level),
    .st_next (st_next),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= bchc_pkg::PH_IDLE;
      st.elapsed      <= '0;
      st.edge_latched <= 1'b0;
      st.last_level   <= 1'b1;
      st.colour       <= bchc_pkg::COL_OFF;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  // two-entry result queue
  assign q_pop     = out_valid && out_ready;
  assign out_valid = q_count != 2'd0;
  assign q_head    = q_mem[q_rd];

  always_comb begin
    q_count_next = q_count;
    if (s1_fire && !q_pop) begin
      q_count_next = q_count + 2'd1;
    end else if (!s1_fire && q_pop) begin
      q_count_next = q_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
      q_wr    <= 1'b0;
      q_rd    <= 1'b0;
    end else begin
      q_count <= q_count_next;
      if (s1_fire) begin
        q_wr <= ~q_wr;
      end
      if (q_pop) begin
        q_rd <= ~q_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      q_mem[q_wr] <= step_res;
    end
  end

  assign red_on       = q_head.red_on;
  assign green_on     = q_head.green_on;
  assign blue_on      = q_head.blue_on;
  assign colour_index = q_head.colour_index;
  assign click_seen   = q_head.click_seen;
  assign hold_seen    = q_head.hold_seen;

  // checks
  `ASSERT_NEVER(a_q_over, q_count == 2'd3, "result queue count out of range")
  `ASSERT_NEVER(a_click_and_hold, step_res.click_seen && step_res.hold_seen, "click with hold")
  `ASSERT_CLK(a_hold_clears,
    s1_fire && step_res.hold_seen |=> st.colour == bchc_pkg::COL_OFF, "hold left colour on")
  `ASSERT_CLK(a_wait_has_edge, st.phase != bchc_pkg::PH_IDLE |-> st.edge_latched, "no edge")
  `ASSERT_CLK(a_no_drop, s1_valid && !s1_fire |=> s1_valid && $stable(s1_level), "tick lost")

endmodule

/* tb/tb_button_click_hold_classifier.sv */
// Self-checking testbench for the button click/hold classifier.
`timescale 1ns / 1ps

module tb_button_click_hold_classifier;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int SETTLE_CYCLES = 4;

  // DUT connections; the DUT inputs are driven from time zero
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         button_level = 1'b1;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         red_on;
  logic                         green_on;
  logic                         blue_on;
  logic [bchc_pkg::ColourW-1:0] colour_index;
  logic                         click_seen;
  logic                         hold_seen;
  logic                         cfg_write = 1'b0;
  logic [bchc_pkg::CfgIdxW-1:0] cfg_index = bchc_pkg::CFG_DEBOUNCE;
  logic [bchc_pkg::TickW-1:0]   cfg_data = '0;

  // Predicted lamp/event results, oldest first
  bchc_pkg::res_t pending_lamps[$];

  // Shadow of the press classifier
  bchc_pkg::phase_t             cur_phase;
  logic [bchc_pkg::TickW-1:0]   wait_count;
  logic                         edge_flag;
  logic                         prev_level;
  logic [bchc_pkg::ColourW-1:0] cur_colour;
  logic [bchc_pkg::TickW-1:0]   deb_len;
  logic [bchc_pkg::TickW-1:0]   click_len;
  logic [bchc_pkg::TickW-1:0]   hold_len;

  // Traffic shaping and bookkeeping
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_off_req = 0;
  int unsigned hold_off_seen = 0;
  int unsigned hold_off_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned clicks_seen = 0;
  int unsigned holds_seen = 0;
  int unsigned timing_sets = 0;

  button_click_hold_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red_on       (red_on),
    .green_on     (green_on),
    .blue_on      (blue_on),
    .colour_index (colour_index),
    .click_seen   (click_seen),
    .hold_seen    (hold_seen),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Press classifier prediction
  // ---------------------------------------------------------------------------

  function automatic void reset_classifier();
    cur_phase  = bchc_pkg::PH_IDLE;
    wait_count = '0;
    edge_flag  = 1'b0;
    prev_level = 1'b1;
    cur_colour = bchc_pkg::COL_OFF;
    deb_len    = bchc_pkg::DEBOUNCE_RST;
    click_len  = bchc_pkg::CLICK_RST;
    hold_len   = bchc_pkg::HOLD_RST;
  endfunction

  // Every return to idle drops a latched edge
  function automatic void back_to_idle();
    cur_phase  = bchc_pkg::PH_IDLE;
    wait_count = '0;
    edge_flag  = 1'b0;
  endfunction

  function automatic void start_wait(input bchc_pkg::phase_t nxt);
    cur_phase  = nxt;
    wait_count = '0;
  endfunction

  function automatic void count_wait();
    if (wait_count != bchc_pkg::TICK_MAX) wait_count = wait_count + 16'd1;
  endfunction

  // One tick in, one lamp/event result out
  function automatic bchc_pkg::res_t classify_tick(input logic lvl);
    logic pressed;
    bchc_pkg::res_t r;
    pressed = !lvl;
    r = '0;
    if (prev_level && !lvl) edge_flag = 1'b1;
    case (cur_phase)
      bchc_pkg::PH_IDLE: begin
        if (edge_flag && pressed) start_wait(bchc_pkg::PH_DEBOUNCE);
      end
      bchc_pkg::PH_DEBOUNCE: begin
        if (wait_count >= deb_len) begin
          if (pressed) start_wait(bchc_pkg::PH_CLICK);
          else back_to_idle();
        end else if (!pressed) begin
          back_to_idle();
        end else begin
          count_wait();
        end
      end
      bchc_pkg::PH_CLICK: begin
        if (wait_count >= click_len) begin
          if (pressed) start_wait(bchc_pkg::PH_HOLD);
          else back_to_idle();
        end else if (!pressed) begin
          // click steps red -> green -> blue -> red, off goes to red
          cur_colour = (cur_colour == bchc_pkg::COL_BLUE) ? bchc_pkg::COL_RED
                                                          : cur_colour + 2'd1;
          r.click_seen = 1'b1;
          back_to_idle();
        end else begin
          count_wait();
        end
      end
      default: begin
        if (!pressed) begin
          back_to_idle();
        end else if (wait_count >= hold_len) begin
          cur_colour = bchc_pkg::COL_OFF;
          r.hold_seen = 1'b1;
          back_to_idle();
        end else begin
          count_wait();
        end
      end
    endcase
    prev_level = lvl;
    r.red_on       = (cur_colour == bchc_pkg::COL_RED);
    r.green_on     = (cur_colour == bchc_pkg::COL_GREEN);
    r.blue_on      = (cur_colour == bchc_pkg::COL_BLUE);
    r.colour_index = cur_colour;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    bchc_pkg::res_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (click_seen) clicks_seen++;
      if (hold_seen) holds_seen++;
      if (pending_lamps.size() == 0) begin
        $error("result transaction with no tick pending (colour_index %0d)", colour_index);
        fail_count++;
      end else begin
        want = pending_lamps.pop_front();
        check_field("red_on", want.red_on, red_on);
        check_field("green_on", want.green_on, green_on);
        check_field("blue_on", want.blue_on, blue_on);
        check_field("colour_index", want.colour_index, colour_index);
        check_field("click_seen", want.click_seen, click_seen);
        check_field("hold_seen", want.hold_seen, hold_seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen <= hold_off_req;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one tick; valid stays up after acceptance until the next call decides
  task automatic send_level(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    button_level <= lvl;
    do @(posedge clk); while (!in_ready);
    pending_lamps.push_back(classify_tick(lvl));
    ticks_sent++;
  endtask

  // Stop offering, drain all results, then let the pipeline empty out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_lamps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three wait lengths back to back; only called while idle
  task automatic set_timing(input logic [bchc_pkg::TickW-1:0] deb,
                            input logic [bchc_pkg::TickW-1:0] clk_win,
                            input logic [bchc_pkg::TickW-1:0] hold);
    cfg_write <= 1'b1;
    cfg_index <= bchc_pkg::CFG_DEBOUNCE;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_index <= bchc_pkg::CFG_CLICK;
    cfg_data  <= clk_win;
    @(posedge clk);
    cfg_index <= bchc_pkg::CFG_HOLD;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_write <= 1'b0;
    deb_len   = deb;
    click_len = clk_win;
    hold_len  = hold;
    timing_sets++;
  endtask

  // Short wait length, now and then zero
  function automatic logic [bchc_pkg::TickW-1:0] random_len(input int unsigned max_len);
    if ($urandom_range(9) == 0) return '0;
    return bchc_pkg::TickW'($urandom_range(max_len, 1));
  endfunction

  // Mostly release-then-press sequences of random length, some random bounce
  task automatic run_press_sequences(input int unsigned n_ticks);
    int unsigned sent;
    int unsigned span;
    int unsigned rel;
    int unsigned press;
    sent = 0;
    while (sent < n_ticks) begin
      if ($urandom_range(99) < 80) begin
        span = int'(deb_len) + int'(click_len) + int'(hold_len) + 4;
        if (span > 60) span = 60;
        rel = $urandom_range(3, 1);
        press = $urandom_range(span, 1);
        repeat (rel) send_level(1'b1);
        repeat (press) send_level(1'b0);
        sent += rel + press;
      end else begin
        rel = $urandom_range(8, 1);
        repeat (rel) send_level(1'($urandom_range(1)));
        sent += rel;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    // reset lengths: a short press gives up in debounce
    send_level(1'b1);
    send_level(1'b0);
    send_level(1'b0);
    send_level(1'b1);
    settle();
    set_timing(16'd0, 16'd1, 16'd0);
    // zero debounce: release right after the edge still returns to idle from debounce
    send_level(1'b0);
    send_level(1'b1);
    // clicks from off: red, green, blue, wrap to red
    repeat (4) begin
      send_level(1'b0);
      send_level(1'b0);
      send_level(1'b1);
    end
    // released during the hold wait: nothing happens
    repeat (4) send_level(1'b0);
    send_level(1'b1);
    // held through a zero-length hold wait: lamps off
    repeat (5) send_level(1'b0);
    send_level(1'b1);
    settle();
  endtask

  task automatic test_random_presses();
    int unsigned send_pcts[4] = '{0, 85, 0, 30};
    int unsigned stall_pcts[4] = '{0, 0, 85, 30};
    for (int m = 0; m < 4; m++) begin
      send_idle_pct = send_pcts[m];
      stall_pct = stall_pcts[m];
      repeat (2) begin
        set_timing(random_len(6), random_len(10), random_len(12));
        run_press_sequences(135);
        settle();
      end
    end
  endtask

  task automatic test_extreme_timing();
    send_idle_pct = 30;
    stall_pct = 30;
    set_timing(bchc_pkg::TICK_MAX, bchc_pkg::TICK_MAX, bchc_pkg::TICK_MAX);
    run_press_sequences(60);
    settle();
    set_timing(16'd1, 16'd1, 16'd1);
    run_press_sequences(60);
    settle();
    set_timing(16'd0, 16'd0, 16'd0);
    run_press_sequences(40);
    settle();
  endtask

  // Receiver holds off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    set_timing(16'd2, 16'd4, 16'd5);
    hold_off_req++;
    run_press_sequences(100);
    settle();
  endtask

  initial begin
    reset_classifier();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_presses();
    test_extreme_timing();
    test_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_lamps.size() != 0) begin
      $error("%0d expected results never arrived", pending_lamps.size());
      fail_count++;
    end

    $display("Sent %0d ticks under %0d timing settings; checked %0d results",
             ticks_sent, timing_sets, results_seen);
    $display("Recognized %0d clicks and %0d holds", clicks_seen, holds_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bchc_pkg.sv
rtl/core/bchc_step.sv
rtl/core/button_click_hold_classifier.sv
tb/tb_button_click_hold_classifier.sv
